>>> hw/rtl/nrmc_pkg.sv
package nrmc_pkg;

  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] CHAR_A      = 8'h41;

  localparam int unsigned MAX_SENTENCE_LEN = 128;
  localparam int unsigned TYPE_LEN         = 5;

  localparam logic [3:0] STATUS_FIELD = 4'd2;
  localparam logic [3:0] MODE_FIELD   = 4'd12;
  localparam logic [3:0] FIELD_MAX    = 4'd15;
  localparam logic [7:0] POS_MAX      = 8'd255;
  localparam logic [7:0] POS_LIMIT    = 8'(MAX_SENTENCE_LEN);
  localparam logic [7:0] POS_TYPE_END = 8'(TYPE_LEN);

  typedef struct packed {
    logic       checksum_ok;
    logic [7:0] computed_sum;
    logic [7:0] received_sum;
    logic       is_rmc;
    logic [7:0] status_char;
    logic [7:0] mode_char;
    logic       fix_ok;
    logic       overlong;
  } result_t;

  // Expected character of the sentence type word "GPRMC" at a position.
  function automatic logic [7:0] type_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h47;
      3'd1:    c = 8'h50;
      3'd2:    c = 8'h52;
      3'd3:    c = 8'h4D;
      3'd4:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // {is_digit, value} for a hex digit of either case.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/nrmc_parse.sv
module nrmc_parse (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              byte_valid,
  input  logic [7:0]        byte_data,
  input  logic              advance,
  output logic              emit,
  output nrmc_pkg::result_t result
);

  logic       in_sentence_r, in_sentence_nxt;
  logic [7:0] xor_acc_r, xor_acc_nxt;
  logic       star_seen_r, star_seen_nxt;
  logic [7:0] hex_acc_r, hex_acc_nxt;
  logic       hex_stopped_r, hex_stopped_nxt;
  logic [7:0] char_pos_r, char_pos_nxt;
  logic       type_match_r, type_match_nxt;
  logic [3:0] field_index_r, field_index_nxt;
  logic       field_started_r, field_started_nxt;
  logic [7:0] status_first_r, status_first_nxt;
  logic [1:0] status_len_r, status_len_nxt;   // saturates at 2: only "exactly one" matters
  logic [7:0] mode_first_r, mode_first_nxt;
  logic       too_long_r, too_long_nxt;

  logic       rmc;
  logic       status_v;
  logic [4:0] hex;

  assign emit     = byte_valid && in_sentence_r && (byte_data == nrmc_pkg::CHAR_CR);
  assign rmc      = type_match_r && (char_pos_r >= nrmc_pkg::POS_TYPE_END);
  assign status_v = (status_len_r == 2'd1) && (status_first_r == nrmc_pkg::CHAR_V);
  assign hex      = nrmc_pkg::hex_digit(byte_data);

  always_comb begin
    result.checksum_ok  = star_seen_r && (xor_acc_r == hex_acc_r);
    result.computed_sum = xor_acc_r;
    result.received_sum = hex_acc_r;
    result.is_rmc       = rmc;
    result.status_char  = status_first_r;
    result.mode_char    = mode_first_r;
    result.fix_ok       = rmc && !status_v && (mode_first_r == nrmc_pkg::CHAR_A);
    result.overlong     = too_long_r;
  end

  always_comb begin
    in_sentence_nxt   = in_sentence_r;
    xor_acc_nxt       = xor_acc_r;
    star_seen_nxt     = star_seen_r;
    hex_acc_nxt       = hex_acc_r;
    hex_stopped_nxt   = hex_stopped_r;
    char_pos_nxt      = char_pos_r;
    type_match_nxt    = type_match_r;
    field_index_nxt   = field_index_r;
    field_started_nxt = field_started_r;
    status_first_nxt  = status_first_r;
    status_len_nxt    = status_len_r;
    mode_first_nxt    = mode_first_r;
    too_long_nxt      = too_long_r;

    if (!in_sentence_r) begin
      if (byte_data == nrmc_pkg::CHAR_DOLLAR) begin
        in_sentence_nxt   = 1'b1;
        xor_acc_nxt       = '0;
        star_seen_nxt     = 1'b0;
        hex_acc_nxt       = '0;
        hex_stopped_nxt   = 1'b0;
        char_pos_nxt      = '0;
        type_match_nxt    = 1'b1;
        field_index_nxt   = '0;
        field_started_nxt = 1'b0;
        status_first_nxt  = '0;
        status_len_nxt    = '0;
        mode_first_nxt    = '0;
        too_long_nxt      = 1'b0;
      end
    end else if (byte_data == nrmc_pkg::CHAR_CR) begin
      in_sentence_nxt = 1'b0;
    end else begin
      if (char_pos_r < nrmc_pkg::POS_TYPE_END &&
          byte_data != nrmc_pkg::type_char(char_pos_r[2:0])) begin
        type_match_nxt = 1'b0;
      end
      if (char_pos_r != nrmc_pkg::POS_MAX) begin
        char_pos_nxt = char_pos_r + 8'd1;
      end
      if (char_pos_nxt > nrmc_pkg::POS_LIMIT) begin
        too_long_nxt = 1'b1;
      end

      if (star_seen_r) begin
        if (!hex_stopped_r) begin
          if (hex[4]) begin
            hex_acc_nxt = {hex_acc_r[3:0], hex[3:0]};
          end else begin
            hex_stopped_nxt = 1'b1;
          end
        end
      end else if (byte_data == nrmc_pkg::CHAR_STAR) begin
        star_seen_nxt = 1'b1;
      end else begin
        xor_acc_nxt = xor_acc_r ^ byte_data;
        if (byte_data == nrmc_pkg::CHAR_COMMA) begin
          if (field_index_r != nrmc_pkg::FIELD_MAX) begin
            field_index_nxt = field_index_r + 4'd1;
          end
          field_started_nxt = 1'b0;
        end else begin
          if (!field_started_r) begin
            if (field_index_r == nrmc_pkg::STATUS_FIELD) status_first_nxt = byte_data;
            if (field_index_r == nrmc_pkg::MODE_FIELD)   mode_first_nxt   = byte_data;
          end
          if (field_index_r == nrmc_pkg::STATUS_FIELD && status_len_r != 2'd2) begin
            status_len_nxt = status_len_r + 2'd1;
          end
          field_started_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_sentence_r   <= 1'b0;
      xor_acc_r       <= '0;
      star_seen_r     <= 1'b0;
      hex_acc_r       <= '0;
      hex_stopped_r   <= 1'b0;
      char_pos_r      <= '0;
      type_match_r    <= 1'b1;
      field_index_r   <= '0;
      field_started_r <= 1'b0;
      status_first_r  <= '0;
      status_len_r    <= '0;
      mode_first_r    <= '0;
      too_long_r      <= 1'b0;
    end else if (advance) begin
      in_sentence_r   <= in_sentence_nxt;
      xor_acc_r       <= xor_acc_nxt;
      star_seen_r     <= star_seen_nxt;
      hex_acc_r       <= hex_acc_nxt;
      hex_stopped_r   <= hex_stopped_nxt;
      char_pos_r      <= char_pos_nxt;
      type_match_r    <= type_match_nxt;
      field_index_r   <= field_index_nxt;
      field_started_r <= field_started_nxt;
      status_first_r  <= status_first_nxt;
      status_len_r    <= status_len_nxt;
      mode_first_r    <= mode_first_nxt;
      too_long_r      <= too_long_nxt;
    end
  end

  a_cr_ends_sentence: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && emit) |=> !in_sentence_r)
    else $error("sentence still open after CR");

  a_stop_needs_star: assert property (@(posedge clk) disable iff (!rst_n)
    hex_stopped_r |-> star_seen_r)
    else $error("hex run stopped without a star");

  a_sum_frozen_after_star: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_sentence_r && star_seen_r) |=> $stable(xor_acc_r))
    else $error("running XOR changed after star");

  a_fields_frozen_after_star: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_sentence_r && star_seen_r) |=> $stable(field_index_r))
    else $error("field split after star");

  a_overlong_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
    too_long_r |-> (char_pos_r > nrmc_pkg::POS_LIMIT))
    else $error("overlong flag without length");

endmodule

>>> hw/rtl/nrmc_out.sv
module nrmc_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  nrmc_pkg::result_t load_data,
  output logic              slot_free,
  output logic              out_valid,
  input  logic              out_ready,
  output nrmc_pkg::result_t out_data
);

  logic              valid_r, valid_nxt;
  nrmc_pkg::result_t data_r;

  assign slot_free = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (out_ready) valid_nxt = 1'b0;
    if (load)      valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) data_r <= load_data;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> slot_free)
    else $error("result loaded over a pending transfer");

  a_held_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ready) |=> (valid_r && $stable(data_r)))
    else $error("stalled result changed");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

endmodule

>>> hw/rtl/nmea_rmc_sentence_checker_top.sv
// NMEA RMC sentence checker.
// Input channel: in_valid/in_ready with in_rx_byte, one received byte per
// transfer. Bytes are ignored until '$'; a CR inside a sentence produces one
// result on the out_ channel (out_valid/out_ready) with the checksum compare,
// computed and received sums, GPRMC match, status and mode characters, fix
// flag and overlong flag. Other bytes produce no result.
// A byte is registered in the input register and parsed into the result register,
// from which a CR's result drives the out_ ports. Throughput: one byte per cycle
// while no CR waits on a full result register, set by the single parse stage
// between the input register and the result register.
// Reset (rst_n low, synchronous) drops any open sentence and both stage
// valids. When the receiver stalls, the pending result holds; bytes that make
// no result keep flowing, and a second CR waits in the input register, which
// then deasserts in_ready until the result register frees.
module nmea_rmc_sentence_checker_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_checksum_ok,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum,
  output logic       out_is_rmc,
  output logic [7:0] out_status_char,
  output logic [7:0] out_mode_char,
  output logic       out_fix_ok,
  output logic       out_overlong
);

  logic              byte_valid_r;
  logic [7:0]        byte_r;
  logic              emit;
  logic              slot_free;
  logic              advance;
  nrmc_pkg::result_t parsed;
  nrmc_pkg::result_t res;

  assign advance  = byte_valid_r && (!emit || slot_free);
  assign in_ready = !byte_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_valid_r <= 1'b0;
    end else if (in_ready) begin
      byte_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) byte_r <= in_rx_byte;
  end

  nrmc_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_valid_r),
    .byte_data  (byte_r),
    .advance    (advance),
    .emit       (emit),
    .result     (parsed)
  );

  nrmc_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && emit),
    .load_data (parsed),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res)
  );

  assign out_checksum_ok  = res.checksum_ok;
  assign out_computed_sum = res.computed_sum;
  assign out_received_sum = res.received_sum;
  assign out_is_rmc       = res.is_rmc;
  assign out_status_char  = res.status_char;
  assign out_mode_char    = res.mode_char;
  assign out_fix_ok       = res.fix_ok;
  assign out_overlong     = res.overlong;

endmodule

>>> tb/nmea_rmc_sentence_checker_top_tb.sv
`timescale 1ns / 1ps

module nmea_rmc_sentence_checker_top_tb;

  localparam int HOLD_CYCLES = 250;
  localparam int STALL_LIMIT = 4000;
  localparam int N_BYTES     = 1400;

  typedef enum int {
    TAIL_GOOD,
    TAIL_LOWER,
    TAIL_BAD,
    TAIL_NONE,
    TAIL_ONE,
    TAIL_THREE,
    TAIL_JUNK
  } tail_e;

  // Tracks the sentence parser and holds the results owed for each CR.
  class rmc_result_scoreboard;
    string             type_word = "GPRMC";
    bit                open;
    bit                star;
    bit                hex_done;
    bit                word_ok;
    bit                long_seen;
    logic [7:0]        body_xor;
    logic [7:0]        star_hex;
    logic [7:0]        pos;
    logic [3:0]        fld;
    logic [7:0]        fld_len;
    logic [7:0]        stat_c;
    logic [7:0]        stat_len;
    logic [7:0]        mode_c;
    nrmc_pkg::result_t pending_results[$];
    int                n_bad;

    function void take_byte(logic [7:0] c);
      nrmc_pkg::result_t r;
      logic [3:0]        nib;
      bit                is_hex;
      bit                rmc;
      if (!open) begin
        if (c == nrmc_pkg::CHAR_DOLLAR) begin
          open      = 1;
          star      = 0;
          hex_done  = 0;
          word_ok   = 1;
          long_seen = 0;
          body_xor  = '0;
          star_hex  = '0;
          pos       = '0;
          fld       = '0;
          fld_len   = '0;
          stat_c    = '0;
          stat_len  = '0;
          mode_c    = '0;
        end
        return;
      end
      if (c == nrmc_pkg::CHAR_CR) begin
        rmc            = word_ok && pos >= nrmc_pkg::TYPE_LEN;
        r.checksum_ok  = star && body_xor == star_hex;
        r.computed_sum = body_xor;
        r.received_sum = star_hex;
        r.is_rmc       = rmc;
        r.status_char  = stat_c;
        r.mode_char    = mode_c;
        // void only when the status field is a lone V
        r.fix_ok       = rmc && !(stat_len == 8'd1 && stat_c == nrmc_pkg::CHAR_V) &&
                         mode_c == nrmc_pkg::CHAR_A;
        r.overlong     = long_seen;
        pending_results.push_back(r);
        open = 0;
        return;
      end
      if (pos < nrmc_pkg::TYPE_LEN && c != type_word[pos]) word_ok = 0;
      if (pos != nrmc_pkg::POS_MAX) pos++;
      if (pos > nrmc_pkg::MAX_SENTENCE_LEN) long_seen = 1;
      if (star) begin
        if (!hex_done) begin
          is_hex = 1;
          nib    = '0;
          if (c >= "0" && c <= "9") nib = c[3:0];
          else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 10);
          else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 10);
          else is_hex = 0;
          if (is_hex) star_hex = {star_hex[3:0], nib};
          else hex_done = 1;
        end
        return;
      end
      if (c == nrmc_pkg::CHAR_STAR) begin
        star = 1;
        return;
      end
      body_xor ^= c;
      if (c == nrmc_pkg::CHAR_COMMA) begin
        if (fld != nrmc_pkg::FIELD_MAX) fld++;
        fld_len = '0;
        return;
      end
      if (fld_len == 8'd0) begin
        if (fld == nrmc_pkg::STATUS_FIELD) stat_c = c;
        if (fld == nrmc_pkg::MODE_FIELD) mode_c = c;
      end
      if (fld == nrmc_pkg::STATUS_FIELD && stat_len != 8'hFF) stat_len++;
      if (fld_len != 8'hFF) fld_len++;
    endfunction

    task flag(string what);
      $display("%0t: mismatch: %s", $time, what);
      n_bad++;
    endtask

    task cmp_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want) flag($sformatf("%s got %0h want %0h", name, got, want));
    endtask

    task check_result(nrmc_pkg::result_t got);
      nrmc_pkg::result_t want;
      if (pending_results.size() == 0) begin
        flag("result with no sentence pending");
        return;
      end
      want = pending_results.pop_front();
      cmp_field("checksum_ok", 8'(got.checksum_ok), 8'(want.checksum_ok));
      cmp_field("computed_sum", got.computed_sum, want.computed_sum);
      cmp_field("received_sum", got.received_sum, want.received_sum);
      cmp_field("is_rmc", 8'(got.is_rmc), 8'(want.is_rmc));
      cmp_field("status_char", got.status_char, want.status_char);
      cmp_field("mode_char", got.mode_char, want.mode_char);
      cmp_field("fix_ok", 8'(got.fix_ok), 8'(want.fix_ok));
      cmp_field("overlong", 8'(got.overlong), 8'(want.overlong));
    endtask
  endclass

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_ready  = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic       out_checksum_ok;
  logic [7:0] out_computed_sum;
  logic [7:0] out_received_sum;
  logic       out_is_rmc;
  logic [7:0] out_status_char;
  logic [7:0] out_mode_char;
  logic       out_fix_ok;
  logic       out_overlong;

  rmc_result_scoreboard sb = new();
  logic [7:0] frame[$];
  bit         tx_fast;
  bit         rx_fast;
  bit         hold_req;
  int         n_bytes;
  int         idle_cycles;

  nmea_rmc_sentence_checker_top i_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.take_byte(in_rx_byte);
      if (out_valid && out_ready) begin
        sb.check_result({out_checksum_ok, out_computed_sum, out_received_sum, out_is_rmc,
                         out_status_char, out_mode_char, out_fix_ok, out_overlong});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("[nmea_rmc_sentence_checker_top] ERROR");
      $finish;
    end
  end

  // result side: random stalls, fast stretches, and one long hold on request
  initial begin
    int gap;
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 15) == 0) rx_fast = !rx_fast;
      gap = rx_fast ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid && !hold_req) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    n_bytes++;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic void push_text(string s);
    foreach (s[i]) frame.push_back(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] v, bit lower);
    if (v < 4'd10) return 8'("0" + v);
    return lower ? 8'("a" + v - 10) : 8'("A" + v - 10);
  endfunction

  function automatic logic [7:0] any_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == nrmc_pkg::CHAR_CR);
    return b;
  endfunction

  // frame[0] is the dollar; the sum covers everything after it
  function automatic void push_tail(tail_e kind);
    logic [7:0] s;
    s = '0;
    for (int i = 1; i < frame.size(); i++) s ^= frame[i];
    if (kind == TAIL_BAD) s ^= 8'($urandom_range(1, 255));
    if (kind == TAIL_NONE) return;
    frame.push_back(nrmc_pkg::CHAR_STAR);
    case (kind)
      TAIL_ONE: frame.push_back(hex_char(s[3:0], 1'($urandom_range(0, 1))));
      TAIL_THREE: begin
        repeat (3) frame.push_back(hex_char(4'($urandom_range(0, 15)),
                                            1'($urandom_range(0, 1))));
      end
      TAIL_JUNK: begin
        frame.push_back(hex_char(s[7:4], 1'b0));
        repeat ($urandom_range(1, 4)) frame.push_back(any_byte());
      end
      default: begin
        frame.push_back(hex_char(s[7:4], kind == TAIL_LOWER));
        frame.push_back(hex_char(s[3:0], kind == TAIL_LOWER));
      end
    endcase
  endfunction

  task automatic send_frame();
    foreach (frame[i]) send_byte(frame[i]);
    frame.delete();
  endtask

  task automatic send_line(string s, tail_e kind);
    push_text(s);
    push_tail(kind);
    frame.push_back(nrmc_pkg::CHAR_CR);
    send_frame();
  endtask

  function automatic void push_field(int k);
    if (k == nrmc_pkg::STATUS_FIELD) begin
      case ($urandom_range(0, 5))
        0: push_text("V");
        1: ;
        2: push_text("VV");
        3: frame.push_back(any_byte());
        default: push_text("A");
      endcase
    end else if (k == nrmc_pkg::MODE_FIELD) begin
      case ($urandom_range(0, 5))
        0: push_text("D");
        1: push_text("N");
        2: ;
        3: push_text("AV");
        4: frame.push_back(any_byte());
        default: push_text("A");
      endcase
    end else begin
      repeat ($urandom_range(0, 4)) begin
        frame.push_back(($urandom_range(0, 7) == 0) ? any_byte()
                                                   : 8'($urandom_range(8'h2E, 8'h39)));
      end
    end
  endfunction

  // mostly well-formed RMC lines with random content; some noise and broken ones
  task automatic rand_sentence();
    int nf;
    int pick;
    tx_fast = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end
    frame.push_back(nrmc_pkg::CHAR_DOLLAR);
    case ($urandom_range(0, 9))
      0: push_text("GPGGA");
      1: push_text("GNRMC");
      2: push_text("gprmc");
      3: push_text("GPRM");
      4: repeat ($urandom_range(0, 7)) frame.push_back(8'($urandom_range(8'h41, 8'h5A)));
      default: push_text("GPRMC");
    endcase
    nf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 17) : 12;
    for (int k = 1; k <= nf; k++) begin
      frame.push_back(nrmc_pkg::CHAR_COMMA);
      push_field(k);
    end
    if ($urandom_range(0, 39) == 0) begin
      repeat ($urandom_range(100, 220)) frame.push_back(8'($urandom_range(8'h30, 8'h39)));
    end
    pick = $urandom_range(0, 10);
    push_tail(pick < 5 ? TAIL_GOOD : pick == 5 ? TAIL_LOWER : tail_e'(pick - 4));
    // now and then the CR is lost and the next dollar lands inside this line
    if ($urandom_range(0, 19) != 0) begin
      frame.push_back(nrmc_pkg::CHAR_CR);
    end
    send_frame();
  endtask

  initial begin
    string rmc_line;
    string short_line;
    int    lens[3];
    rmc_line   = "$GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W,A";
    short_line = "$GPRMC,1,A,,,,,,,,,,A";
    lens       = '{126, 127, 262};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // outside a sentence everything is dropped, a CR too
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(nrmc_pkg::CHAR_CR);
    send_byte("G");
    send_line(rmc_line, TAIL_GOOD);
    send_line(rmc_line, TAIL_LOWER);
    send_line("$GPRMC,081836,V,3751.65,S,14507.36,E,000.0,360.0,130998,011.3,E,A", TAIL_GOOD);
    send_line("$GPRMC,1,VA,,,,,,,,,,A", TAIL_GOOD);
    send_line("$GPRMC,,,,,,,,,,,,", TAIL_GOOD);
    send_line("$GPRMC,1,A,,,,,,,,,,D", TAIL_LOWER);
    send_line("$GPGGA,123519,A,,,,,,,,,,A", TAIL_GOOD);
    send_line("$GPR", TAIL_NONE);
    send_line("$", TAIL_NONE);
    send_line(short_line, TAIL_NONE);
    send_line(short_line, TAIL_BAD);
    send_line(short_line, TAIL_ONE);
    send_line(short_line, TAIL_THREE);
    send_line(short_line, TAIL_JUNK);
    send_line("$GPRMC,,A*G1", TAIL_NONE);
    send_line("$GPRMC,,A**12", TAIL_NONE);
    send_line("$GPRMC,,A*1,2,A", TAIL_NONE);
    send_line("$GPRMC,,,,,,,,,,,,,,,,,,,,X,A", TAIL_GOOD);
    send_line("$$GPRMC,,A,,,,,,,,,,A", TAIL_GOOD);
    push_text("$GPRMC,$,A,");
    frame.push_back(8'h00);
    frame.push_back(8'hFF);
    frame.push_back(8'h80);
    send_line(",,,,,,,,A", TAIL_GOOD);
    // 128 bytes after the dollar is fine, 129 is overlong, past 255 saturates the count
    foreach (lens[j]) begin
      push_text("$GPRMC,A");
      while (frame.size() < lens[j]) frame.push_back("0");
      send_line("", TAIL_GOOD);
    end
    wait_results_drained();

    // stall the result side and keep pushing short lines until the input backs up
    hold_req = 1'b1;
    tx_fast  = 1'b1;
    repeat (3) send_line("$GPRMC,,A,,,,,,,,,,A", TAIL_GOOD);
    wait_results_drained();

    while (n_bytes < N_BYTES) rand_sentence();
    wait_results_drained();
    repeat (10) @(posedge clk);
    if (sb.n_bad == 0) begin
      $display("[nmea_rmc_sentence_checker_top] OK");
    end else begin
      $display("[nmea_rmc_sentence_checker_top] ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/nrmc_pkg.sv
hw/rtl/nrmc_parse.sv
hw/rtl/nrmc_out.sv
hw/rtl/nmea_rmc_sentence_checker_top.sv
tb/nmea_rmc_sentence_checker_top_tb.sv
